### src/utx_pkg.sv
// utx_pkg: shared types, encoding codes and output encoder functions
// for the unicode transcoder
// no dependencies
package utx_pkg;

  localparam int UNIT_W  = 32;
  localparam int POINT_W = 21;

  // encoding codes, shared by source and target registers
  localparam logic [1:0] ENC_ASCII = 2'd0;
  localparam logic [1:0] ENC_UTF8  = 2'd1;
  localparam logic [1:0] ENC_UTF16 = 2'd2;
  localparam logic [1:0] ENC_UTF32 = 2'd3;

  // register indexes on the apb port
  localparam logic REG_SOURCE = 1'b0;
  localparam logic REG_TARGET = 1'b1;

  localparam logic [UNIT_W-1:0] REPLACEMENT = 32'h0000_003F;

  // one decoded code point on its way from front to back
  typedef struct packed {
    logic              valid;
    logic [UNIT_W-1:0] point;
  } point_t;

  // number of units a code point takes in the target encoding (0 to 4)
  function automatic logic [2:0] enc_count(input logic [UNIT_W-1:0] cp,
                                           input logic [1:0] tgt);
    logic [2:0] n;
    begin
      n = 3'd1;
      case (tgt)
        ENC_UTF8: begin
          if (cp < 32'h80) n = 3'd1;
          else if (cp < 32'h800) n = 3'd2;
          else if (cp < 32'h1_0000) n = 3'd3;
          else n = 3'd4;
        end
        ENC_UTF16: begin
          if (cp < 32'hD800 || (cp >= 32'hE000 && cp < 32'h1_0000)) n = 3'd1;
          else if (cp >= 32'h1_0000 && cp < 32'h11_0000) n = 3'd2;
          else n = 3'd0;
        end
        default: n = 3'd1;
      endcase
      return n;
    end
  endfunction

  // unit number idx of a code point in the target encoding
  function automatic logic [UNIT_W-1:0] enc_unit(input logic [UNIT_W-1:0] cp,
                                                 input logic [1:0] tgt,
                                                 input logic [1:0] idx);
    logic [UNIT_W-1:0] u;
    logic [2:0]        n;
    logic [POINT_W-1:0] iv;
    begin
      n  = enc_count(cp, tgt);
      iv = cp[POINT_W-1:0] - 21'h1_0000;
      u  = cp;
      case (tgt)
        ENC_ASCII: u = (cp > 32'h7F) ? REPLACEMENT : cp;
        ENC_UTF8: begin
          case (n)
            3'd1: u = cp;
            3'd2: begin
              if (idx == 2'd0) u = {24'd0, cp[13:6] | 8'hC0};
              else u = {24'd0, 2'b10, cp[5:0]};
            end
            3'd3: begin
              case (idx)
                2'd0:    u = {24'd0, cp[19:12] | 8'hE0};
                2'd1:    u = {24'd0, 2'b10, cp[11:6]};
                default: u = {24'd0, 2'b10, cp[5:0]};
              endcase
            end
            default: begin
              case (idx)
                2'd0:    u = {24'd0, cp[25:18] | 8'hF0};
                2'd1:    u = {24'd0, 2'b10, cp[17:12]};
                2'd2:    u = {24'd0, 2'b10, cp[11:6]};
                default: u = {24'd0, 2'b10, cp[5:0]};
              endcase
            end
          endcase
        end
        ENC_UTF16: begin
          if (n == 3'd2) begin
            // surrogate pair: high half then low half
            if (idx == 2'd0) u = {16'd0, 6'b110110, iv[19:10]};
            else u = {16'd0, 6'b110111, cp[9:0]};
          end else begin
            u = cp;
          end
        end
        default: u = cp;
      endcase
      return u;
    end
  endfunction

endpackage

### src/utx_if.sv
// utx_if: handshake channels for code units in and encoded units out
// depends on utx_pkg for the unit width
interface utx_unit_in_if;
  import utx_pkg::*;
  logic              valid;
  logic              ready;
  logic [UNIT_W-1:0] code_unit;

  modport source (output valid, output code_unit, input ready);
  modport sink (input valid, input code_unit, output ready);
endinterface

interface utx_unit_out_if;
  import utx_pkg::*;
  logic              valid;
  logic              ready;
  logic [UNIT_W-1:0] out_unit;
  logic              last_unit;

  modport source (output valid, output out_unit, output last_unit, input ready);
  modport sink (input valid, input out_unit, input last_unit, output ready);
endinterface

### src/utx_front.sv
// utx_front: accepts source code units and collects complete code points
// depends on utx_pkg
module utx_front import utx_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        source_encoding,
  input  logic              clear,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [UNIT_W-1:0] code_unit,
  input  logic              queue_full,
  output point_t            push
);

  logic [POINT_W-1:0] partial_point, partial_point_next;
  logic [1:0]         units_pending, units_pending_next;
  logic [POINT_W-1:0] cont_bits;
  logic [POINT_W-1:0] merged;
  logic [7:0]         byte_val;
  logic [15:0]        half;
  logic               decoded;
  logic [UNIT_W-1:0]  point;

  assign in_ready = !queue_full;
  assign byte_val = code_unit[7:0];
  assign half     = code_unit[15:0];

  // continuation bits placed by the number of units still expected
  always_comb begin
    case (units_pending)
      2'd1:    cont_bits = {15'd0, byte_val[5:0]};
      2'd2:    cont_bits = {9'd0, byte_val[5:0], 6'd0};
      default: cont_bits = {3'd0, byte_val[5:0], 12'd0};
    endcase
    merged = partial_point | cont_bits;
  end

  // decode one unit
  always_comb begin
    decoded            = 1'b0;
    point              = code_unit;
    partial_point_next = partial_point;
    units_pending_next = units_pending;
    unique case (source_encoding)
      ENC_ASCII: begin
        decoded = 1'b1;
        point   = {24'd0, byte_val};
      end
      ENC_UTF8: begin
        if (units_pending != 2'd0) begin
          units_pending_next = units_pending - 2'd1;
          if (units_pending == 2'd1) begin
            decoded            = 1'b1;
            point              = {11'd0, merged};
            partial_point_next = '0;
          end else begin
            partial_point_next = merged;
          end
        end else if (!byte_val[7]) begin
          decoded = 1'b1;
          point   = {24'd0, byte_val};
        end else if (byte_val[7:5] == 3'b110) begin
          partial_point_next = {10'd0, byte_val[4:0], 6'd0};
          units_pending_next = 2'd1;
        end else if (byte_val[7:4] == 4'hE) begin
          partial_point_next = {5'd0, byte_val[3:0], 12'd0};
          units_pending_next = 2'd2;
        end else if (byte_val[7:3] == 5'h1E) begin
          partial_point_next = {byte_val[2:0], 18'd0};
          units_pending_next = 2'd3;
        end else begin
          decoded = 1'b1;
          point   = REPLACEMENT;
        end
      end
      ENC_UTF16: begin
        if (units_pending != 2'd0) begin
          // any unit closes an open pair
          decoded            = 1'b1;
          point              = {11'd0, partial_point + {11'd0, half[9:0]}};
          partial_point_next = '0;
          units_pending_next = 2'd0;
        end else if (half < 16'hD800 || half >= 16'hE000) begin
          decoded = 1'b1;
          point   = {16'd0, half};
        end else if (half < 16'hDC00) begin
          partial_point_next = 21'h1_0000 + {1'b0, half[9:0], 10'd0};
          units_pending_next = 2'd1;
        end else begin
          // lone low surrogate
          decoded = 1'b1;
          point   = REPLACEMENT;
        end
      end
      ENC_UTF32: begin
        decoded = 1'b1;
        point   = code_unit;
      end
      default: begin
        decoded = 1'b0;
      end
    endcase
  end

  assign push.valid = in_valid && in_ready && decoded;
  assign push.point = point;

  // sequence state, dropped on a source encoding write
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      partial_point <= '0;
      units_pending <= '0;
    end else if (in_valid && in_ready) begin
      partial_point <= partial_point_next;
      units_pending <= units_pending_next;
    end
  end

endmodule

### src/utx_queue.sv
// utx_queue: short queue of decoded code points between front and back
// depends on utx_pkg
module utx_queue import utx_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  point_t push,
  input  logic   pop,
  output point_t head,
  output logic   full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [UNIT_W-1:0] entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign full       = (count == FULL_CNT);
  assign head.valid = (count != '0);
  assign head.point = entries[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.point;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop) rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### src/utx_back.sv
// utx_back: encodes queued code points into target units, one per cycle while the output is not stalled
// depends on utx_pkg
module utx_back import utx_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        target_encoding,
  input  point_t            head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [UNIT_W-1:0] out_unit,
  output logic              out_last
);

  logic [1:0]        idx;
  logic [2:0]        count;
  logic              slot_free;
  logic              emit;
  logic              is_last;
  logic [UNIT_W-1:0] unit_val;

  assign count     = enc_count(head.point, target_encoding);
  assign unit_val  = enc_unit(head.point, target_encoding, idx);
  assign is_last   = ({1'b0, idx} == count - 3'd1);
  assign slot_free = !out_valid || out_ready;
  assign emit      = slot_free && head.valid && (count != 3'd0);
  // points with no units are dropped straight away
  assign pop       = slot_free && head.valid && ((count == 3'd0) || is_last);

  // unit index within the current code point
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (emit) begin
      idx <= is_last ? 2'd0 : idx + 2'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_unit <= unit_val;
      out_last <= is_last;
    end
  end

endmodule

### src/unicode_transcoder.sv
// Unicode transcoder: takes one source code unit per transaction on code_chan
// in the encoding set by register 0 (0 ascii, 1 utf8, 2 utf16, 3 utf32) and
// gives the code point as 0 to 4 units in the encoding set by register 1 on
// result_chan, with last_unit high on the final unit of each code point.
// Registers sit on an APB port at byte addresses 0 and 4; writing the source
// encoding drops any open sequence. The user must see that writes are made
// while the block is idle; the block itself does not enforce this. A code unit
// is taken every cycle while the code point queue has room; the output side
// gives one unit a cycle while result_chan is not stalled, and units that close
// no code point give no output. A unit that closes a code point is stored in
// the queue and then in the output register before its first output unit.
// Depends on utx_pkg, utx_if, utx_front, utx_queue and utx_back.
module unicode_transcoder import utx_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  utx_unit_in_if.sink           code_chan,
  utx_unit_out_if.source        result_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [1:0] source_encoding;
  logic [1:0] target_encoding;
  logic       cfg_write;
  logic       source_clear;
  logic       queue_full;
  logic       pop;
  point_t     push;
  point_t     head;

  // configuration registers
  assign pready       = 1'b1;
  assign cfg_write    = psel && penable && pwrite && pready;
  assign source_clear = cfg_write && (paddr[2] == REG_SOURCE);

  always_ff @(posedge clk) begin
    if (rst) begin
      source_encoding <= ENC_UTF8;
      target_encoding <= ENC_UTF16;
    end else if (cfg_write) begin
      if (paddr[2] == REG_SOURCE) source_encoding <= pwdata[1:0];
      else target_encoding <= pwdata[1:0];
    end
  end

  assign prdata = (paddr[2] == REG_TARGET) ? {30'd0, target_encoding}
                                           : {30'd0, source_encoding};

  // decode side
  utx_front u_front (
    .clk             (clk),
    .rst             (rst),
    .source_encoding (source_encoding),
    .clear           (source_clear),
    .in_valid        (code_chan.valid),
    .in_ready        (code_chan.ready),
    .code_unit       (code_chan.code_unit),
    .queue_full      (queue_full),
    .push            (push)
  );

  // code point queue
  utx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (queue_full)
  );

  // encode side
  utx_back u_back (
    .clk             (clk),
    .rst             (rst),
    .target_encoding (target_encoding),
    .head            (head),
    .pop             (pop),
    .out_valid       (result_chan.valid),
    .out_ready       (result_chan.ready),
    .out_unit        (result_chan.out_unit),
    .out_last        (result_chan.last_unit)
  );

endmodule

### src/utx_checker.sv
// utx_checker: port-level checks on the unicode transcoder, bound to its top
// depends on utx_pkg and unicode_transcoder
module utx_checker import utx_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [UNIT_W-1:0] out_unit,
  input logic              last_unit,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic              pready,
  input logic [2:0]        paddr,
  input logic [31:0]       pwdata
);

  logic [1:0] target_shadow;

  // track the target encoding from apb writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_shadow <= ENC_UTF16;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TARGET) begin
      target_shadow <= pwdata[1:0];
    end
  end

  // a stalled transaction holds its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_unit) && $stable(last_unit))
    else $error("stalled output transaction changed");

  // no output straight after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // ascii target: single 7-bit unit per code point
  assert property (@(posedge clk) disable iff (rst)
    out_valid && target_shadow == ENC_ASCII |-> out_unit <= 32'h7F && last_unit)
    else $error("ascii output out of range");

  // utf8 target: bytes only
  assert property (@(posedge clk) disable iff (rst)
    out_valid && target_shadow == ENC_UTF8 |-> out_unit[31:8] == '0)
    else $error("utf8 output wider than a byte");

  // utf16 target: 16-bit units, a high surrogate never ends a code point
  assert property (@(posedge clk) disable iff (rst)
    out_valid && target_shadow == ENC_UTF16 |->
      out_unit[31:16] == '0 && !(last_unit && out_unit[15:10] == 6'b110110))
    else $error("utf16 output malformed");

endmodule

bind unicode_transcoder utx_checker u_utx_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result_chan.valid),
  .out_ready (result_chan.ready),
  .out_unit  (result_chan.out_unit),
  .last_unit (result_chan.last_unit),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .pready    (pready),
  .paddr     (paddr),
  .pwdata    (pwdata)
);

### sim/unicode_transcoder_tb.sv
`timescale 1ns / 1ps
// unicode_transcoder_tb: self-checking bench for the unicode transcoder, directed table then
// random code points in fixed and random encoding pairs, checked by an in-bench decoder/encoder
// depends on utx_pkg, utx_if and unicode_transcoder
module unicode_transcoder_tb;
  import utx_pkg::*;

  localparam int DIR_N        = 25;
  localparam int PHASES       = 10;
  localparam int PHASE_UNITS  = 20;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 150;
  localparam int MAX_PRINTS   = 50;
  localparam longint TIMEOUT_NS = 4_000_000;
  localparam logic [3:0][31:0] NO_UNITS = '0;

  // one directed stimulus row; u and n are only used where typed is set
  typedef struct packed {
    logic [1:0]       src;
    logic [1:0]       tgt;
    logic [31:0]      unit;
    logic             typed;
    logic [2:0]       n;
    logic [3:0][31:0] u;
  } drow_t;

  typedef struct packed {
    logic [31:0] unit;
    logic        last;
  } coded_unit_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  utx_unit_in_if  code_if ();
  utx_unit_out_if res_if ();

  unicode_transcoder u_top (
    .clk         (clk),
    .rst         (rst),
    .code_chan   (code_if),
    .result_chan (res_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // decoder state and register copies
  logic [1:0]  cur_src;
  logic [1:0]  cur_tgt;
  logic [20:0] acc_point;
  logic [1:0]  cont_left;

  coded_unit_t due_units[$];
  coded_unit_t head;
  drow_t       dir_rows [DIR_N];

  int mismatches;
  int units_sent;
  int burst_left;
  int hold_req;
  bit valid_up;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("unicode_transcoder_tb NOT OK");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatches < MAX_PRINTS)
      $display("%0t mismatch, %s: got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic drow_t mk_row(input logic [1:0] src, input logic [1:0] tgt,
                                   input logic [31:0] unit, input int typed,
                                   input int n, input logic [31:0] u0,
                                   input logic [31:0] u1, input logic [31:0] u2,
                                   input logic [31:0] u3);
    drow_t r;
    r.src   = src;
    r.tgt   = tgt;
    r.unit  = unit;
    r.typed = 1'(typed);
    r.n     = 3'(n);
    r.u     = {u3, u2, u1, u0};
    return r;
  endfunction

  // decode one source unit, then encode a finished code point in the target encoding
  function automatic int transcode_step(input logic [31:0] unit,
                                        output logic [3:0][31:0] units);
    logic [31:0] cp;
    logic [7:0]  b;
    logic [15:0] w;
    logic [31:0] offv;
    int          n;
    units = '0;
    cp    = unit;
    n     = 0;
    case (cur_src)
      ENC_ASCII: cp = {24'd0, unit[7:0]};
      ENC_UTF8: begin
        b = unit[7:0];
        if (cont_left != 2'd0) begin
          // continuation: low six bits land at their place, top bits unchecked
          acc_point = acc_point + (21'(b[5:0]) << (6 * (int'(cont_left) - 1)));
          cont_left = cont_left - 2'd1;
          if (cont_left != 2'd0) return 0;
          cp        = {11'd0, acc_point};
          acc_point = '0;
        end else if (b < 8'h80) begin
          cp = {24'd0, b};
        end else if (b[7:5] == 3'b110) begin
          acc_point = {10'd0, b[4:0], 6'd0};
          cont_left = 2'd1;
          return 0;
        end else if (b[7:4] == 4'hE) begin
          acc_point = {5'd0, b[3:0], 12'd0};
          cont_left = 2'd2;
          return 0;
        end else if (b[7:3] == 5'h1E) begin
          acc_point = {b[2:0], 18'd0};
          cont_left = 2'd3;
          return 0;
        end else begin
          cp = REPLACEMENT;
        end
      end
      ENC_UTF16: begin
        w = unit[15:0];
        if (cont_left != 2'd0) begin
          // second half of a pair, whatever its value
          cp        = {11'd0, acc_point} + {22'd0, w[9:0]};
          acc_point = '0;
          cont_left = 2'd0;
        end else if (w < 16'hD800 || w >= 16'hE000) begin
          cp = {16'd0, w};
        end else if (w < 16'hDC00) begin
          acc_point = 21'h1_0000 + {1'b0, w[9:0], 10'd0};
          cont_left = 2'd1;
          return 0;
        end else begin
          cp = REPLACEMENT;
        end
      end
      default: cp = unit;
    endcase

    case (cur_tgt)
      ENC_ASCII: begin
        units[0] = (cp > 32'h7F) ? REPLACEMENT : cp;
        n        = 1;
      end
      ENC_UTF8: begin
        if (cp < 32'h80) begin
          units[0] = cp;
          n        = 1;
        end else if (cp < 32'h800) begin
          units[0] = (cp >> 6) | 32'hC0;
          units[1] = (cp & 32'h3F) | 32'h80;
          n        = 2;
        end else if (cp < 32'h1_0000) begin
          units[0] = (cp >> 12) | 32'hE0;
          units[1] = ((cp >> 6) & 32'h3F) | 32'h80;
          units[2] = (cp & 32'h3F) | 32'h80;
          n        = 3;
        end else begin
          units[0] = ((cp >> 18) | 32'hF0) & 32'hFF;
          units[1] = ((cp >> 12) & 32'h3F) | 32'h80;
          units[2] = ((cp >> 6) & 32'h3F) | 32'h80;
          units[3] = (cp & 32'h3F) | 32'h80;
          n        = 4;
        end
      end
      ENC_UTF16: begin
        if (cp < 32'hD800 || (cp >= 32'hE000 && cp < 32'h1_0000)) begin
          units[0] = cp;
          n        = 1;
        end else if (cp >= 32'h1_0000 && cp < 32'h11_0000) begin
          offv     = cp - 32'h1_0000;
          units[0] = 32'hD800 + {22'd0, offv[19:10]};
          units[1] = 32'hDC00 + {22'd0, offv[9:0]};
          n        = 2;
        end else begin
          // surrogate points and out-of-range values vanish
          n = 0;
        end
      end
      default: begin
        units[0] = cp;
        n        = 1;
      end
    endcase
    return n;
  endfunction

  // one apb transaction, setup then access
  task automatic apb_cycle(input logic wr, input logic idx, input logic [31:0] data,
                           output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input logic idx, input logic [1:0] val);
    logic [31:0] rd;
    apb_cycle(1'b1, idx, {30'd0, val}, rd);
    apb_cycle(1'b0, idx, 32'd0, rd);
    if (rd !== {30'd0, val}) flag_mismatch("register read-back", rd, {30'd0, val});
  endtask

  task automatic sender_rest();
    if (valid_up) begin
      code_if.valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  // registers change only once the block has drained
  task automatic set_encodings(input logic [1:0] src, input logic [1:0] tgt);
    sender_rest();
    while (due_units.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (src != cur_src) begin
      write_reg(REG_SOURCE, src);
      cur_src   = src;
      acc_point = '0;
      cont_left = 2'd0;
    end
    if (tgt != cur_tgt) begin
      write_reg(REG_TARGET, tgt);
      cur_tgt = tgt;
    end
  endtask

  // offer one unit, predict on acceptance, then keep or end the burst
  task automatic send_unit(input logic [31:0] unit, input logic typed, input logic [2:0] tn,
                           input logic [3:0][31:0] tu);
    logic [3:0][31:0] pu;
    int               pn;
    coded_unit_t      cu;
    code_if.valid     <= 1'b1;
    code_if.code_unit <= unit;
    valid_up = 1'b1;
    do @(posedge clk); while (!code_if.ready);
    pn = transcode_step(unit, pu);
    if (typed) begin
      pn = int'(tn);
      pu = tu;
    end
    for (int k = 0; k < pn; k++) begin
      cu.unit = pu[k];
      cu.last = (k == pn - 1);
      due_units.push_back(cu);
    end
    units_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      code_if.valid <= 1'b0;
      valid_up = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
  endtask

  // one random code point in the source encoding, or some noise
  task automatic send_point(input logic [1:0] src);
    logic [31:0] cp;
    logic [31:0] r;
    logic [31:0] offv;
    logic [7:0]  b;
    int          cls;
    int          nb;
    int          pick;
    r   = $urandom();
    cls = $urandom_range(0, 3);
    case (cls)
      0:       cp = $urandom_range(0, 'h7F);
      1:       cp = $urandom_range('h80, 'h7FF);
      2:       cp = $urandom_range('h800, 'hFFFF);
      default: cp = $urandom_range('h1_0000, 'h10_FFFF);
    endcase
    case (src)
      ENC_ASCII: send_unit(r, 1'b0, 3'd0, NO_UNITS);
      ENC_UTF8: begin
        if ($urandom_range(0, 9) < 2) begin
          send_unit(r, 1'b0, 3'd0, NO_UNITS);
        end else begin
          if (cls == 3 && $urandom_range(0, 7) == 0) cp = $urandom_range('h11_0000, 'h1F_FFFF);
          nb = cls + 1;
          for (int k = 0; k < nb; k++) begin
            if (nb == 1) b = cp[7:0];
            else if (k == 0) begin
              case (nb)
                2:       b = 8'hC0 | {3'd0, cp[10:6]};
                3:       b = 8'hE0 | {4'd0, cp[15:12]};
                default: b = 8'hF0 | {5'd0, cp[20:18]};
              endcase
            end else begin
              b = {2'b10, cp[6 * (nb - 1 - k) +: 6]};
              // the block ignores the marker bits of a continuation byte
              if ($urandom_range(0, 9) == 0) b[7:6] = 2'($urandom_range(0, 3));
            end
            r = $urandom();
            send_unit($urandom_range(0, 1) ? {r[31:8], b} : {24'd0, b}, 1'b0, 3'd0, NO_UNITS);
          end
        end
      end
      ENC_UTF16: begin
        if ($urandom_range(0, 19) < 3) begin
          send_unit(r, 1'b0, 3'd0, NO_UNITS);
        end else if (cls == 3) begin
          offv = cp - 32'h1_0000;
          send_unit({r[31:16], 6'b110110, offv[19:10]}, 1'b0, 3'd0, NO_UNITS);
          r = $urandom();
          send_unit({r[31:16], 6'b110111, offv[9:0]}, 1'b0, 3'd0, NO_UNITS);
        end else begin
          send_unit({r[31:16], cp[15:0]}, 1'b0, 3'd0, NO_UNITS);
        end
      end
      default: begin
        pick = $urandom_range(0, 9);
        if (pick < 6) send_unit(cp, 1'b0, 3'd0, NO_UNITS);
        else if (pick < 8) send_unit($urandom_range('hD800, 'hDFFF), 1'b0, 3'd0, NO_UNITS);
        else send_unit(r, 1'b0, 3'd0, NO_UNITS);
      end
    endcase
  endtask

  // receiver: changing stall pattern, plus long hold-offs on request
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    res_if.ready <= 1'b0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 48);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        case (mode)
          0:       res_if.ready <= 1'b1;
          1:       res_if.ready <= ($urandom_range(0, 3) != 0);
          2:       res_if.ready <= 1'($urandom_range(0, 1));
          default: res_if.ready <= (mode_left % 4 == 0);
        endcase
      end
    end
  end

  // compare each result transaction with the oldest expected unit
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (due_units.size() == 0) begin
        flag_mismatch("result with nothing expected", res_if.out_unit, 32'd0);
      end else begin
        head = due_units.pop_front();
        if (res_if.out_unit !== head.unit)
          flag_mismatch("out_unit", res_if.out_unit, head.unit);
        if (res_if.last_unit !== head.last)
          flag_mismatch("last_unit", {31'd0, res_if.last_unit}, {31'd0, head.last});
      end
    end
  end

  // stimulus
  initial begin
    drow_t      row;
    logic [1:0] src;
    logic [1:0] tgt;
    int         goal;
    bit         held;
    bit         paused;

    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    code_if.valid     <= 1'b0;
    code_if.code_unit <= '0;
    cur_src    = ENC_UTF8;
    cur_tgt    = ENC_UTF16;
    acc_point  = '0;
    cont_left  = 2'd0;
    mismatches = 0;
    units_sent = 0;
    burst_left = 0;
    hold_req   = 0;
    valid_up   = 1'b0;
    held       = 1'b0;
    paused     = 1'b0;

    // settings after reset
    dir_rows[0]  = mk_row(ENC_UTF8, ENC_UTF16, 32'h0000_0000, 1, 1, 32'h0, 0, 0, 0);
    // stray continuation byte and 11111xxx as lead bytes
    dir_rows[1]  = mk_row(ENC_UTF8, ENC_UTF16, 32'hFFFF_FF80, 1, 1, REPLACEMENT, 0, 0, 0);
    dir_rows[2]  = mk_row(ENC_UTF8, ENC_UTF16, 32'h0000_00FF, 1, 1, REPLACEMENT, 0, 0, 0);
    // highest code point, four bytes in, surrogate pair out
    dir_rows[3]  = mk_row(ENC_UTF8, ENC_UTF16, 32'h0000_00F4, 1, 0, 0, 0, 0, 0);
    dir_rows[4]  = mk_row(ENC_UTF8, ENC_UTF16, 32'h0000_008F, 1, 0, 0, 0, 0, 0);
    dir_rows[5]  = mk_row(ENC_UTF8, ENC_UTF16, 32'h0000_00BF, 1, 0, 0, 0, 0, 0);
    dir_rows[6]  = mk_row(ENC_UTF8, ENC_UTF16, 32'h0000_00BF, 1, 2, 32'hDBFF, 32'hDFFF, 0, 0);
    // surrogate point from three bytes gives no utf16 output
    dir_rows[7]  = mk_row(ENC_UTF8, ENC_UTF16, 32'h0000_00ED, 1, 0, 0, 0, 0, 0);
    dir_rows[8]  = mk_row(ENC_UTF8, ENC_UTF16, 32'h0000_00A0, 1, 0, 0, 0, 0, 0);
    dir_rows[9]  = mk_row(ENC_UTF8, ENC_UTF16, 32'h0000_0080, 1, 0, 0, 0, 0, 0);
    // continuation byte with bad marker bits is still taken
    dir_rows[10] = mk_row(ENC_UTF8, ENC_UTF8, 32'h0000_00C3, 1, 0, 0, 0, 0, 0);
    dir_rows[11] = mk_row(ENC_UTF8, ENC_UTF8, 32'h0000_00FF, 0, 0, 0, 0, 0, 0);
    // open sequence, then dropped by the source write
    dir_rows[12] = mk_row(ENC_UTF8, ENC_UTF8, 32'h0000_00E2, 1, 0, 0, 0, 0, 0);
    dir_rows[13] = mk_row(ENC_ASCII, ENC_UTF8, 32'h0000_00E9, 1, 2, 32'hC3, 32'hA9, 0, 0);
    dir_rows[14] = mk_row(ENC_ASCII, ENC_ASCII, 32'hFFFF_FFFF, 1, 1, REPLACEMENT, 0, 0, 0);
    dir_rows[15] = mk_row(ENC_ASCII, ENC_ASCII, 32'h0000_007F, 1, 1, 32'h7F, 0, 0, 0);
    // lone low surrogate, then a pair closed by an arbitrary unit
    dir_rows[16] = mk_row(ENC_UTF16, ENC_UTF32, 32'h0001_DC00, 1, 1, REPLACEMENT, 0, 0, 0);
    dir_rows[17] = mk_row(ENC_UTF16, ENC_UTF32, 32'h0000_D83D, 1, 0, 0, 0, 0, 0);
    dir_rows[18] = mk_row(ENC_UTF16, ENC_UTF32, 32'hFFFF_0000, 0, 0, 0, 0, 0, 0);
    dir_rows[19] = mk_row(ENC_UTF16, ENC_UTF32, 32'h0000_FFFF, 1, 1, 32'hFFFF, 0, 0, 0);
    // utf8 out: truncated four-byte form and a surrogate as three bytes
    dir_rows[20] = mk_row(ENC_UTF32, ENC_UTF8, 32'hFFFF_FFFF, 1, 4,
                          32'hFF, 32'hBF, 32'hBF, 32'hBF);
    dir_rows[21] = mk_row(ENC_UTF32, ENC_UTF8, 32'h0000_DFFF, 1, 3, 32'hED, 32'hBF, 32'hBF, 0);
    dir_rows[22] = mk_row(ENC_UTF32, ENC_UTF16, 32'h0011_0000, 1, 0, 0, 0, 0, 0);
    dir_rows[23] = mk_row(ENC_UTF32, ENC_ASCII, 32'h0000_0080, 1, 1, REPLACEMENT, 0, 0, 0);
    dir_rows[24] = mk_row(ENC_UTF32, ENC_UTF32, 32'h8000_0000, 1, 1, 32'h8000_0000, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < DIR_N; i++) begin
      row = dir_rows[i];
      if (row.src != cur_src || row.tgt != cur_tgt) set_encodings(row.src, row.tgt);
      send_unit(row.unit, row.typed, row.n, row.u);
    end

    // random phases, first ones fixed to reach every encoding value
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin src = ENC_ASCII; tgt = ENC_UTF32; end
        1:       begin src = ENC_UTF32; tgt = ENC_ASCII; end
        2:       begin src = ENC_UTF8;  tgt = ENC_UTF8;  end
        3:       begin src = ENC_UTF16; tgt = ENC_UTF16; end
        4:       begin src = ENC_UTF8;  tgt = ENC_ASCII; end
        5:       begin src = ENC_UTF16; tgt = ENC_UTF32; end
        default: begin src = 2'($urandom_range(0, 3)); tgt = 2'($urandom_range(0, 3)); end
      endcase
      if (src != cur_src || tgt != cur_tgt) set_encodings(src, tgt);
      goal = units_sent + PHASE_UNITS;
      while (units_sent < goal) begin
        // long receiver hold-off while the sender keeps offering
        if (ph == 2 && !held && units_sent >= goal - 18) begin
          hold_req = HOLD_CYCLES;
          held     = 1'b1;
        end
        // sender pause until every result is out
        if (ph == 5 && !paused && units_sent >= goal - 12) begin
          sender_rest();
          while (due_units.size() != 0) @(posedge clk);
          @(posedge clk);
          paused = 1'b1;
        end
        send_point(src);
      end
    end

    // drain and finish
    sender_rest();
    while (due_units.size() != 0) @(posedge clk);
    repeat (4 * DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_units.size() == 0) begin
      $display("unicode_transcoder_tb OK");
    end else begin
      $display("unicode_transcoder_tb NOT OK");
    end
    $finish;
  end

endmodule
